### hdl/mqrbf_pkg.sv
// Shared types and constants for the multiquadric RBF evaluator.
// No dependencies; imported by every module of the block but mqrbf_ram.
package mqrbf_pkg;

   localparam int COORD_W  = 16;
   localparam int WEIGHT_W = 32;
   localparam int ACC_W    = 48;
   localparam int CFG_W    = 32;
   localparam int IDX_W    = 8;
   localparam int NCFG_W   = 9;
   localparam int DIMS_W   = 3;
   localparam int SUM_W    = 36;                // sum of squares plus epsilon, Q.16
   localparam int RAD_W    = SUM_W + 16;        // radicand, Q.32
   localparam int ROOT_W   = RAD_W / 2;         // root, Q.16
   localparam int REM_W    = ROOT_W + 2;
   localparam int ENTRY_W  = 4 * COORD_W + WEIGHT_W;

   localparam logic [1:0] REG_EPSILON = 2'd0;
   localparam logic [1:0] REG_ALPHA   = 2'd1;
   localparam logic [1:0] REG_CENTERS = 2'd2;
   localparam logic [1:0] REG_DIMS    = 2'd3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                       op;
      logic [IDX_W-1:0]           index;
      logic [3:0][COORD_W-1:0]    coord;   // x in lane 0 .. w in lane 3
      logic signed [WEIGHT_W-1:0] weight;
   } item_type;

   typedef struct packed {
      logic [CFG_W-1:0]  epsilon_squared;
      logic [CFG_W-1:0]  offset_alpha;
      logic [NCFG_W-1:0] centers_in_use;
      logic [DIMS_W-1:0] dims_in_use;
   } cfg_type;

endpackage

### hdl/mqrbf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mqrbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### hdl/mqrbf_front.sv
// Front end: accepts items and holds them in a two-entry queue for the back end.
// Depends on mqrbf_pkg.
module mqrbf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mqrbf_pkg::item_type in_item,
   output logic                head_valid,
   output mqrbf_pkg::item_type head_item,
   input  logic                head_pop
);
   import mqrbf_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign busy       = (count_ff == 2'd2);
   assign push       = start && !busy;
   assign head_valid = (count_ff != 2'd0);
   assign pop        = head_pop && head_valid;
   assign head_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

### hdl/mqrbf_back.sv
// Back end: table writes and the per-center distance / root / weighted-sum sequencer.
// Depends on mqrbf_pkg and mqrbf_ram.
module mqrbf_back #(
   parameter int MAX_CENTERS = 256,
   parameter int MAX_DIMS    = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  mqrbf_pkg::cfg_type  cfg,
   input  logic                head_valid,
   input  mqrbf_pkg::item_type head_item,
   output logic                head_pop,
   output logic                rsp_valid,
   output logic signed [mqrbf_pkg::ACC_W-1:0] rsp_interpolated_value,
   output logic                rsp_saturated
);
   import mqrbf_pkg::*;

   localparam int AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int CW = $clog2(MAX_CENTERS + 1);
   localparam int RCNT_W = $clog2(ROOT_W);
   localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W:0] ACC_MIN = {2'b11, {(ACC_W-1){1'b0}}};

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_READ  = 9'b000000010,
      S_DIFF  = 9'b000000100,
      S_SUM   = 9'b000001000,
      S_ROOT  = 9'b000010000,
      S_MUL   = 9'b000100000,
      S_ACC   = 9'b001000000,
      S_ALPHA = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               i_ff, i_in;
   logic [CW-1:0]               n_ff, n_in;
   logic [DIMS_W-1:0]           dims_ff, dims_in;
   logic [3:0][COORD_W-1:0]     pt_ff, pt_in;
   logic [3:0][31:0]            sq_ff, sq_in;
   logic [RAD_W-1:0]            x_ff, x_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [ROOT_W-1:0]           root_ff, root_in;
   logic [RCNT_W-1:0]           rcnt_ff, rcnt_in;
   logic signed [WEIGHT_W+ROOT_W:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        clip_ff, clip_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic [ENTRY_W-1:0]          wr_data, rd_data;
   logic [3:0][COORD_W-1:0]     c_coord;
   logic signed [WEIGHT_W-1:0]  c_weight;
   logic [CW-1:0]               n_eff;
   logic [DIMS_W-1:0]           dims_eff;
   logic [SUM_W-1:0]            sum_sq;
   logic [REM_W+1:0]            rem_sh, trial;
   logic signed [ACC_W:0]       add_a, add_b, add_s;
   logic signed [ACC_W-1:0]     sat_val;
   logic                        sat_clip;
   logic                        idx_ok;

   assign wr_data = {head_item.weight, head_item.coord};
   assign wr_addr = AW'(head_item.index);
   assign idx_ok  = ({24'd0, head_item.index} < 32'(MAX_CENTERS));
   assign wr_en   = (state_ff == S_IDLE) && head_valid && (head_item.op == OP_LOAD) && idx_ok;
   assign rd_addr = i_ff[AW-1:0];
   assign head_pop = (state_ff == S_IDLE);

   mqrbf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CENTERS)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign c_coord  = rd_data[4*COORD_W-1:0];
   assign c_weight = rd_data[ENTRY_W-1:4*COORD_W];

   always_comb begin
      n_eff = (32'(cfg.centers_in_use) > 32'(MAX_CENTERS)) ?
              CW'(MAX_CENTERS) : CW'(cfg.centers_in_use);
      if (cfg.dims_in_use == '0) begin
         dims_eff = DIMS_W'(1);
      end else if (32'(cfg.dims_in_use) > 32'(MAX_DIMS)) begin
         dims_eff = DIMS_W'(MAX_DIMS);
      end else begin
         dims_eff = cfg.dims_in_use;
      end
   end

   // one square per lane, inactive lanes contribute zero
   always_comb begin
      logic signed [COORD_W:0]     d;
      logic signed [2*COORD_W+1:0] p;
      for (int k = 0; k < 4; k++) begin
         d = {c_coord[k][COORD_W-1], c_coord[k]} - {pt_ff[k][COORD_W-1], pt_ff[k]};
         p = d * d;
         sq_in[k] = (32'(k) < 32'(dims_ff)) ? p[31:0] : 32'd0;
      end
   end

   assign sum_sq = SUM_W'(cfg.epsilon_squared) + SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1])
                 + SUM_W'(sq_ff[2]) + SUM_W'(sq_ff[3]);

   // one root bit per cycle
   assign rem_sh = {rem_ff, x_ff[RAD_W-1:RAD_W-2]};
   assign trial  = {2'b00, root_ff, 2'b01};

   // saturating adder shared by the center terms and the offset
   always_comb begin
      add_a = {acc_ff[ACC_W-1], acc_ff};
      if (state_ff == S_ALPHA) begin
         add_b = (ACC_W+1)'(signed'(cfg.offset_alpha));
      end else begin
         add_b = (ACC_W+1)'(prod_ff >>> 16);
      end
      add_s = add_a + add_b;
      sat_clip = 1'b0;
      if (add_s > ACC_MAX) begin
         sat_val  = ACC_MAX[ACC_W-1:0];
         sat_clip = 1'b1;
      end else if (add_s < ACC_MIN) begin
         sat_val  = ACC_MIN[ACC_W-1:0];
         sat_clip = 1'b1;
      end else begin
         sat_val = add_s[ACC_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      dims_in      = dims_ff;
      pt_in        = pt_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rcnt_in      = rcnt_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      clip_in      = clip_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (head_valid && head_item.op == OP_QUERY) begin
               pt_in   = head_item.coord;
               n_in    = n_eff;
               dims_in = dims_eff;
               i_in    = '0;
               acc_in  = '0;
               clip_in = 1'b0;
               state_in = (n_eff == '0) ? S_ALPHA : S_READ;
            end
         end
         S_READ: state_in = S_DIFF;
         S_DIFF: state_in = S_SUM;
         S_SUM: begin
            x_in     = {sum_sq, 16'd0};
            rem_in   = '0;
            root_in  = '0;
            rcnt_in  = RCNT_W'(ROOT_W - 1);
            state_in = S_ROOT;
         end
         S_ROOT: begin
            x_in = x_ff << 2;
            if (rem_sh >= trial) begin
               rem_in  = REM_W'(rem_sh - trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_sh);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            rcnt_in = rcnt_ff - RCNT_W'(1);
            if (rcnt_ff == '0) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = c_weight * $signed({1'b0, root_ff});
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in  = sat_val;
            clip_in = clip_ff | sat_clip;
            i_in    = i_ff + CW'(1);
            state_in = (i_ff + CW'(1) == n_ff) ? S_ALPHA : S_READ;
         end
         S_ALPHA: begin
            acc_in   = sat_val;
            clip_in  = clip_ff | sat_clip;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      n_ff    <= n_in;
      dims_ff <= dims_in;
      pt_ff   <= pt_in;
      sq_ff   <= sq_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rcnt_ff <= rcnt_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      clip_ff <= clip_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interpolated_value = acc_ff;
   assign rsp_saturated          = clip_ff;

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state not one-hot");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE)
      else $error("result shown while busy");
   a_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_ACC) |-> i_ff < n_ff)
      else $error("center index past count");
   a_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid)
      else $error("finished query gave no result");
`endif
endmodule

### hdl/multiquadric_rbf_evaluate.sv
// Top level of the multiquadric RBF evaluator: CSRs, front queue and back sequencer.
// Depends on mqrbf_pkg, mqrbf_front, mqrbf_back (and mqrbf_ram beneath it).
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  req     | in        | start / busy              | op, index, 4 coords, weight
//  rsp     | out       | rsp_valid strobe, 1 cycle | interpolated_value, saturated
//  csr     | in        | csr_valid / csr_ready     | csr_index, csr_wdata
//
// A load is written to the table from the idle state. A query walks, for each of the
// n centers in use, through read, diff, sum, ROOT_W root steps, multiply and
// accumulate, then adds alpha and raises the result strobe; the back end takes no new
// item before that strobe. The one-bit-per-cycle root unit is the long pole. Reset is synchronous;
// the table is not cleared, so a center must be loaded before any query reads it.
// busy rises when the two-beat queue is full; results cannot be held off by the receiver.
module multiquadric_rbf_evaluate #(
   parameter int MAX_CENTERS = 256,
   parameter int MAX_DIMS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [7:0]  req_center_index,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [15:0] req_coord_z,
   input  logic signed [15:0] req_coord_w,
   input  logic signed [31:0] req_center_weight,
   output logic        rsp_valid,
   output logic signed [47:0] rsp_interpolated_value,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import mqrbf_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type in_item, head_item;
   logic     head_valid, head_pop;

   // config regs always take a beat
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_EPSILON: cfg_in.epsilon_squared = csr_wdata;
            REG_ALPHA:   cfg_in.offset_alpha    = csr_wdata;
            REG_CENTERS: cfg_in.centers_in_use  = csr_wdata[NCFG_W-1:0];
            REG_DIMS:    cfg_in.dims_in_use     = csr_wdata[DIMS_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.epsilon_squared <= '0;
         cfg_ff.offset_alpha    <= '0;
         cfg_ff.centers_in_use  <= '0;
         cfg_ff.dims_in_use     <= DIMS_W'(2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pack the request beat
   assign in_item.op     = req_op;
   assign in_item.index  = req_center_index;
   assign in_item.coord  = {req_coord_w, req_coord_z, req_coord_y, req_coord_x};
   assign in_item.weight = req_center_weight;

   mqrbf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .in_item   (in_item),
      .head_valid(head_valid),
      .head_item (head_item),
      .head_pop  (head_pop)
   );

   mqrbf_back #(.MAX_CENTERS(MAX_CENTERS), .MAX_DIMS(MAX_DIMS)) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .head_valid            (head_valid),
      .head_item             (head_item),
      .head_pop              (head_pop),
      .rsp_valid             (rsp_valid),
      .rsp_interpolated_value(rsp_interpolated_value),
      .rsp_saturated         (rsp_saturated)
   );
endmodule

### verif/multiquadric_rbf_evaluate_tb.sv
// Testbench for multiquadric_rbf_evaluate: center loads and point queries with a
// bit-exact predictor, random config phases and random start idling.
// Depends on mqrbf_pkg and the multiquadric_rbf_evaluate RTL.
`timescale 1ns / 100ps

module multiquadric_rbf_evaluate_tb;
   import mqrbf_pkg::*;

   localparam int     NSLOT     = 256;
   localparam int     WDOG_MAX  = 100000;
   localparam longint ACC_HI    = (64'sd1 <<< 47) - 1;
   localparam longint ACC_LO    = -(64'sd1 <<< 47);

   typedef struct {
      logic [47:0] value;
      logic        sat;
   } rbf_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_op;
   logic [7:0]  req_center_index;
   logic signed [15:0] req_coord_x, req_coord_y, req_coord_z, req_coord_w;
   logic signed [31:0] req_center_weight;
   logic        rsp_valid;
   logic signed [47:0] rsp_interpolated_value;
   logic        rsp_saturated;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   multiquadric_rbf_evaluate u_top (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_op                 (req_op),
      .req_center_index       (req_center_index),
      .req_coord_x            (req_coord_x),
      .req_coord_y            (req_coord_y),
      .req_coord_z            (req_coord_z),
      .req_coord_w            (req_coord_w),
      .req_center_weight      (req_center_weight),
      .rsp_valid              (rsp_valid),
      .rsp_interpolated_value (rsp_interpolated_value),
      .rsp_saturated          (rsp_saturated),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Mirror of the block's registers and center table, updated on accepted beats
   // ---------------------------------------------------------------------------
   logic [31:0]        eps_sq_q;
   logic [31:0]        alpha_q;
   logic [8:0]         n_centers_q;
   logic [2:0]         n_dims_q;
   logic [15:0]        tbl_coord [NSLOT][4];
   logic [31:0]        tbl_weight [NSLOT];

   item_type           pending_items[$];
   rbf_result_type     expected_results[$];
   int                 mismatches;
   int                 watchdog_cnt;
   bit                 idle_enable;

   // generator side: which slots hold a loaded center (queries never read others)
   bit                 slot_loaded [NSLOT];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // floor(sqrt(x)), digit-by-digit
   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r = 0;
      longint unsigned b = 64'h1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clamp_acc(longint s, inout bit clip);
      if (s > ACC_HI) begin
         clip = 1'b1;
         return ACC_HI;
      end
      if (s < ACC_LO) begin
         clip = 1'b1;
         return ACC_LO;
      end
      return s;
   endfunction

   // Weighted multiquadric sum for one query point, using the mirrored state.
   function automatic rbf_result_type interpolate_point(item_type it);
      rbf_result_type  res;
      int              n, dims;
      longint          acc, d, w, term;
      longint unsigned s, root;
      bit              clip;
      n    = (n_centers_q > NSLOT) ? NSLOT : int'(n_centers_q);
      dims = (n_dims_q < 1) ? 1 : (n_dims_q > 4) ? 4 : int'(n_dims_q);
      acc  = 0;
      clip = 1'b0;
      for (int i = 0; i < n; i++) begin
         s = longint'(eps_sq_q);
         for (int k = 0; k < dims; k++) begin
            d = longint'($signed(tbl_coord[i][k])) - longint'($signed(it.coord[k]));
            s += d * d;
         end
         root = floor_sqrt(s << 16);
         w    = longint'($signed(tbl_weight[i]));
         term = (w * $signed(root)) >>> 16;   // floor toward minus infinity
         acc  = clamp_acc(acc + term, clip);
      end
      acc = clamp_acc(acc + longint'($signed(alpha_q)), clip);
      res.value = acc[47:0];
      res.sat   = clip;
      return res;
   endfunction

   // Apply one accepted beat to the mirror; queries queue their expected result.
   task automatic absorb_item(item_type it);
      if (it.op == OP_LOAD) begin
         for (int k = 0; k < 4; k++) tbl_coord[it.index][k] = it.coord[k];
         tbl_weight[it.index] = it.weight;
      end else begin
         expected_results.insert(expected_results.size(), interpolate_point(it));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Request driver: pops pending items, idles in random bursts
   // ---------------------------------------------------------------------------
   item_type cur_item;
   int       gap_cnt;

   always @(posedge clock) begin
      if (reset) begin
         start   <= 1'b0;
         gap_cnt = 0;
      end else begin
         if (start && !busy) absorb_item(cur_item);
         if (!start || !busy) begin
            if (gap_cnt > 0) begin
               gap_cnt--;
               start <= 1'b0;
            end else if (pending_items.size() > 0) begin
               cur_item = pending_items.pop_front();
               req_op            <= cur_item.op;
               req_center_index  <= cur_item.index;
               req_coord_x       <= cur_item.coord[0];
               req_coord_y       <= cur_item.coord[1];
               req_coord_z       <= cur_item.coord[2];
               req_coord_w       <= cur_item.coord[3];
               req_center_weight <= cur_item.weight;
               start             <= 1'b1;
               if (idle_enable && $urandom_range(0, 3) == 0) gap_cnt = $urandom_range(1, 5);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor: one-cycle strobe, compared in order
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rbf_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value=%h sat=%b",
                        rsp_interpolated_value, rsp_saturated);
         end else begin
            want = expected_results.pop_front();
            if (rsp_interpolated_value !== want.value || rsp_saturated !== want.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: value exp=%h got=%h, sat exp=%b got=%b",
                           want.value, rsp_interpolated_value, want.sat, rsp_saturated);
            end
         end
      end
   end

   // Watchdog: cycles without any accepted beat on any channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         watchdog_cnt = 0;
      else
         watchdog_cnt++;
      if (watchdog_cnt >= WDOG_MAX) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_EPSILON: eps_sq_q    = data;
         REG_ALPHA:   alpha_q     = data;
         REG_CENTERS: n_centers_q = data[8:0];
         REG_DIMS:    n_dims_q    = data[2:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [31:0] eps, logic [31:0] alpha, logic [8:0] n,
                             logic [2:0] dims);
      csr_write(REG_EPSILON, eps);
      csr_write(REG_ALPHA, alpha);
      csr_write(REG_CENTERS, {23'd0, n});
      csr_write(REG_DIMS, {29'd0, dims});
   endtask

   // Block is idle: nothing queued, nothing presented, nothing outstanding.
   // Loads give no result, so the task also waits for the last one to retire.
   task automatic drain;
      while (pending_items.size() > 0 || start || gap_cnt > 0 ||
             expected_results.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // append one item to the driver's backlog
   task automatic queue_item(item_type it);
      pending_items.insert(pending_items.size(), it);
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_weight();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic item_type make_item(logic op, int idx, logic [31:0] wt);
      item_type it;
      it.op     = op;
      it.index  = idx[7:0];
      for (int k = 0; k < 4; k++) it.coord[k] = rand_coord();
      it.weight = wt;
      if (op == OP_LOAD) slot_loaded[idx] = 1'b1;
      return it;
   endfunction

   function automatic item_type fixed_item(logic op, int idx, logic [15:0] c,
                                           logic [31:0] wt);
      item_type it;
      it = make_item(op, idx, wt);
      for (int k = 0; k < 4; k++) it.coord[k] = c;
      return it;
   endfunction

   // Random mix of loads and queries; a query whose centers are not all loaded
   // turns into a load of the first missing slot.
   task automatic queue_random(int count, int n_req);
      int  miss;
      for (int j = 0; j < count; j++) begin
         miss = -1;
         for (int i = 0; i < n_req; i++)
            if (!slot_loaded[i] && miss < 0) miss = i;
         if ($urandom_range(0, 1) == 1 && miss < 0)
            queue_item(make_item(OP_QUERY, $urandom_range(0, 255), $urandom));
         else if (miss >= 0)
            queue_item(make_item(OP_LOAD, miss, rand_weight()));
         else
            queue_item(make_item(OP_LOAD,
               ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7),
               rand_weight()));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [8:0]  n_pick;
      logic [31:0] eps_pick, alpha_pick;
      start = 1'b0;
      req_op = OP_LOAD;
      req_center_index = '0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      req_coord_w = '0;
      req_center_weight = '0;
      csr_valid = 1'b0;
      csr_index = REG_EPSILON;
      csr_wdata = '0;
      mismatches = 0;
      watchdog_cnt = 0;
      idle_enable = 1'b1;
      gap_cnt = 0;
      eps_sq_q = '0;
      alpha_q = '0;
      n_centers_q = '0;
      n_dims_q = 3'd2;
      for (int i = 0; i < NSLOT; i++) begin
         slot_loaded[i] = 1'b0;
         tbl_weight[i] = '0;
         for (int k = 0; k < 4; k++) tbl_coord[i][k] = '0;
      end

      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset config: zero centers, result is just alpha
      queue_item(fixed_item(OP_QUERY, 0, 16'h7fff, 32'h7fff_ffff));
      drain();

      // directed: extreme coords and weights, top slot, max eps and alpha
      set_config(32'hffff_ffff, 32'h7fff_ffff, 9'd4, 3'd4);
      queue_item(fixed_item(OP_LOAD, 0, 16'h8000, 32'h7fff_ffff));
      queue_item(fixed_item(OP_LOAD, 1, 16'h7fff, 32'h8000_0000));
      queue_item(fixed_item(OP_LOAD, 2, 16'h0000, 32'h0000_0000));
      queue_item(fixed_item(OP_LOAD, 3, 16'hffff, 32'hffff_ffff));
      queue_item(fixed_item(OP_LOAD, 255, 16'h7fff, 32'h7fff_ffff));
      queue_item(fixed_item(OP_QUERY, 0, 16'h7fff, 32'h0));
      queue_item(fixed_item(OP_QUERY, 255, 16'h8000, 32'hffff_ffff));
      queue_item(fixed_item(OP_QUERY, 9, 16'h0000, 32'h1234_5678));
      drain();
      // dims 0 acts as 1, dims 7 as 4; zero eps, minimum alpha
      set_config(32'h0, 32'h8000_0000, 9'd4, 3'd0);
      queue_item(fixed_item(OP_QUERY, 0, 16'h7fff, 32'h0));
      queue_item(fixed_item(OP_QUERY, 0, 16'h8000, 32'h0));
      drain();
      set_config(32'h0001_0000, 32'h0, 9'd1, 3'd7);
      queue_item(fixed_item(OP_QUERY, 0, 16'h8000, 32'h0));
      queue_item(fixed_item(OP_LOAD, 0, 16'h1234, 32'h0001_0000));
      queue_item(fixed_item(OP_QUERY, 0, 16'h1234, 32'h0));
      drain();

      // random phases: few centers to keep query time short
      for (int ph = 0; ph < 16; ph++) begin
         n_pick     = $urandom_range(0, 6);
         eps_pick   = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom;
         alpha_pick = ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : $urandom;
         set_config(eps_pick, alpha_pick, n_pick, 3'($urandom_range(0, 7)));
         queue_random(28, int'(n_pick));
         drain();
      end

      // last part: no idling, whole table with big weights so the sum clips;
      // 511 centers saturates to the table size
      idle_enable = 1'b0;
      set_config(32'hffff_ffff, 32'h7fff_ffff, 9'd511, 3'd4);
      for (int i = 0; i < NSLOT; i++)
         queue_item(fixed_item(OP_LOAD, i, (i % 2) ? 16'h7fff : 16'h8000,
                               ($urandom_range(0, 5) == 0) ? $urandom
                                                            : 32'h7fff_ffff));
      for (int j = 0; j < 3; j++)
         queue_item(make_item(OP_QUERY, $urandom_range(0, 255), $urandom));
      drain();
      set_config($urandom, 32'h8000_0000, 9'd256, 3'd3);
      for (int j = 0; j < 2; j++)
         queue_item(make_item(OP_QUERY, $urandom_range(0, 255), $urandom));
      drain();

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
